FILE: sv/rgb_led_animation_sequencer_defines.svh
// assertion macros for the rgb led animation sequencer
// used by the top level, expects signals named clock and reset in scope
`ifndef RGB_LED_ANIMATION_SEQUENCER_DEFINES_SVH
`define RGB_LED_ANIMATION_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RLAS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rlas check failed: same cycle");

// next-cycle implication, disabled during reset
`define RLAS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rlas check failed: next cycle");

// next-cycle implication that also holds across reset
`define RLAS_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rlas check failed: reset");

`endif

FILE: sv/rlas_pkg.sv
// shared types and constants for the rgb led animation sequencer
// no dependencies
package rlas_pkg;

   localparam int LED_COUNT  = 4;
   localparam int LED_IDX_W  = $clog2(LED_COUNT);
   localparam int COLOR_W    = 8;
   localparam int FUNC_W     = 2;
   localparam int MODE_W     = 3;
   localparam int PERIOD_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int ROUNDS_W   = 2;
   localparam int SWEEP_W    = 3;
   localparam int WORD_W     = LED_IDX_W + 1;   // two frames at most per item

   // input function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MODE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CHASE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PULSE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOCK  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHASE_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_PERIOD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_PERIOD  = 2'd3;

   // register reset values
   localparam logic [PERIOD_W-1:0] CHASE_PERIOD_RST = 8'd8;
   localparam logic [PERIOD_W-1:0] PULSE_PERIOD_RST = 8'd4;
   localparam logic [PERIOD_W-1:0] LOCK_PERIOD_RST  = 8'd50;
   localparam logic [PERIOD_W-1:0] OPEN_PERIOD_RST  = 8'd50;
   localparam logic [PERIOD_W-1:0] OFF_PERIOD       = 8'd0;

   // pattern constants
   localparam logic [COLOR_W-1:0] RAMP_STEP = 8'd5;
   localparam logic [COLOR_W-1:0] RAMP_TOP  = 8'd250;
   localparam logic [COLOR_W-1:0] FULL_ON   = 8'd255;
   localparam logic [ROUNDS_W-1:0] PULSE_ROUNDS_END = 2'd3;
   localparam logic [SWEEP_W-1:0]  SWEEP_END = SWEEP_W'(LED_COUNT + 1);

   // job queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] b;
   } color_type;

   typedef color_type [LED_COUNT-1:0] frame_type;

   // one queued job: a frame snapshot sent once or twice
   typedef struct packed {
      frame_type leds;
      logic      power_on;
      logic      twice;
   } job_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/rgb_led_animation_sequencer.sv
// top level of the rgb led animation sequencer: front, job queue, back
// depends on rlas_pkg, rlas_front, rlas_queue, rlas_back and the defines header
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | func, mode
//   rsp     | out       | rsp_valid/stall    | led_sel, green, red, blue, power_on, last
//   csr     | in        | csr_valid/ready    | index, data
//
// the front takes one item per cycle while req_stall is low and updates the animation state at once
// each item with results sends 4 words, a sweep end 8, one word per cycle at the back while rsp_stall is low
// sustained rate is set by the back's word counter, which takes the next job as the last word is taken
// a two-job queue parts front and back; req_stall is high while it is full
// reset is synchronous, active high; csr writes are always ready
`include "rgb_led_animation_sequencer_defines.svh"
module rgb_led_animation_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rlas_pkg::FUNC_W-1:0]     req_func,
   input  logic [rlas_pkg::MODE_W-1:0]     req_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rlas_pkg::LED_IDX_W-1:0]  rsp_led_sel,
   output logic [rlas_pkg::COLOR_W-1:0]    rsp_green,
   output logic [rlas_pkg::COLOR_W-1:0]    rsp_red,
   output logic [rlas_pkg::COLOR_W-1:0]    rsp_blue,
   output logic                            rsp_power_on,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rlas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rlas_pkg::PERIOD_W-1:0]   csr_data
);

   rlas_pkg::queue_status_type q_status;
   rlas_pkg::job_type          push_job, pop_job;
   logic                       push, pop;
   logic                       word_moves;

   rlas_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_mode  (req_mode),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   rlas_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   rlas_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_job         (pop_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_led_sel   (rsp_led_sel),
      .rsp_green     (rsp_green),
      .rsp_red       (rsp_red),
      .rsp_blue      (rsp_blue),
      .rsp_power_on  (rsp_power_on),
      .rsp_last      (rsp_last)
   );

   // a word is taken and more of the same item follow
   assign word_moves = rsp_valid && !rsp_stall && !rsp_last;

   // checks on the word sequencing
   `RLAS_ASSERT_RESET(a_reset_idle, reset, !rsp_valid)
   `RLAS_ASSERT_NOW(a_last_on_fourth, rsp_valid && rsp_last, rsp_led_sel == rlas_pkg::LED_IDX_W'(rlas_pkg::LED_COUNT - 1))
   `RLAS_ASSERT_NEXT(a_frame_continues, word_moves, rsp_valid)
   `RLAS_ASSERT_NEXT(a_index_steps, word_moves, rsp_led_sel == $past(rsp_led_sel) + 1'b1)

endmodule

FILE: sv/rlas_front.sv
// front part: accepts items, holds registers and animation state, builds frame jobs
// depends on rlas_pkg
module rlas_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rlas_pkg::FUNC_W-1:0]   req_func,
   input  logic [rlas_pkg::MODE_W-1:0]   req_mode,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rlas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rlas_pkg::PERIOD_W-1:0] csr_data,
   input  rlas_pkg::queue_status_type    q_status,
   output logic                          push,
   output rlas_pkg::job_type             push_job
);

   logic [rlas_pkg::PERIOD_W-1:0] chase_period_ff, pulse_period_ff;
   logic [rlas_pkg::PERIOD_W-1:0] lock_period_ff, open_period_ff;

   logic                            enable_ff, enable_in;
   logic [rlas_pkg::PERIOD_W-1:0]   phase_ff, phase_in;
   logic [rlas_pkg::MODE_W-1:0]     mode_ff, mode_in;
   rlas_pkg::frame_type             colors_ff, colors_in;
   logic [rlas_pkg::LED_IDX_W-1:0]  chase_ff, chase_in;
   logic                            fade_ff, fade_in;
   logic [rlas_pkg::ROUNDS_W-1:0]   rounds_ff, rounds_in;
   logic [rlas_pkg::SWEEP_W-1:0]    sweep_ff, sweep_in;
   logic                            supply_ff, supply_in;

   logic                            accept;
   logic                            job_valid, job_twice;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chase_period_ff <= rlas_pkg::CHASE_PERIOD_RST;
         pulse_period_ff <= rlas_pkg::PULSE_PERIOD_RST;
         lock_period_ff  <= rlas_pkg::LOCK_PERIOD_RST;
         open_period_ff  <= rlas_pkg::OPEN_PERIOD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rlas_pkg::CSR_CHASE_PERIOD: chase_period_ff <= csr_data;
            rlas_pkg::CSR_PULSE_PERIOD: pulse_period_ff <= csr_data;
            rlas_pkg::CSR_LOCK_PERIOD:  lock_period_ff  <= csr_data;
            rlas_pkg::CSR_OPEN_PERIOD:  open_period_ff  <= csr_data;
         endcase
      end
   end

   // next animation state and job for the item on the input
   always_comb begin
      logic [rlas_pkg::PERIOD_W-1:0]  period;
      logic [rlas_pkg::PERIOD_W-1:0]  phase_inc;
      logic [rlas_pkg::COLOR_W-1:0]   sel_b, new_b, next_b, red0;
      logic [rlas_pkg::LED_IDX_W-1:0] chase_nx;
      logic                           chase_move, chase_on;
      logic [rlas_pkg::SWEEP_W-1:0]   sweep_n;
      logic                           sweep_lit;

      enable_in = enable_ff;
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      colors_in = colors_ff;
      chase_in  = chase_ff;
      fade_in   = fade_ff;
      rounds_in = rounds_ff;
      sweep_in  = sweep_ff;
      supply_in = supply_ff;
      job_valid = 1'b0;
      job_twice = 1'b0;

      unique case (mode_ff)
         rlas_pkg::MODE_CHASE: period = chase_period_ff;
         rlas_pkg::MODE_PULSE: period = pulse_period_ff;
         rlas_pkg::MODE_LOCK:  period = lock_period_ff;
         rlas_pkg::MODE_OPEN:  period = open_period_ff;
         default:              period = rlas_pkg::OFF_PERIOD;
      endcase
      phase_inc = phase_ff + 1'b1;

      // chase ramp on the lit led
      sel_b = colors_ff[chase_ff].b;
      new_b = fade_ff ? (sel_b - rlas_pkg::RAMP_STEP) : (sel_b + rlas_pkg::RAMP_STEP);

      // when the lit led goes dark below the last one, the next led ramps in the same step
      chase_nx   = chase_ff + 1'b1;
      chase_move = fade_ff && (new_b == '0);
      chase_on   = chase_move &&
                   (chase_ff != rlas_pkg::LED_IDX_W'(rlas_pkg::LED_COUNT - 1));
      next_b     = colors_ff[chase_nx].b + rlas_pkg::RAMP_STEP;

      // pulse ramp as seen on the first led
      red0 = colors_ff[0].r + rlas_pkg::RAMP_STEP;

      // sweep position after this step
      sweep_n   = sweep_ff + 1'b1;
      sweep_lit = (sweep_n != '0) && (sweep_n <= rlas_pkg::SWEEP_W'(rlas_pkg::LED_COUNT));

      unique case (req_func)
         rlas_pkg::FUNC_TICK: begin
            if (enable_ff) begin
               phase_in = phase_inc;
               if (phase_inc >= period) begin
                  job_valid = 1'b1;
                  phase_in  = '0;
                  if (mode_ff == rlas_pkg::MODE_CHASE) begin
                     for (int i = 0; i < rlas_pkg::LED_COUNT; i++) begin
                        colors_in[i].g = '0;
                        colors_in[i].r = '0;
                        colors_in[i].b = (rlas_pkg::LED_IDX_W'(i) == chase_ff) ? new_b :
                                         (chase_on && (rlas_pkg::LED_IDX_W'(i) == chase_nx)) ?
                                         next_b : '0;
                     end
                     if (!fade_ff) begin
                        if (new_b > rlas_pkg::RAMP_TOP) fade_in = 1'b1;
                     end else if (new_b == '0) begin
                        fade_in  = chase_on && (next_b > rlas_pkg::RAMP_TOP);
                        chase_in = chase_nx;
                     end
                  end else if (mode_ff == rlas_pkg::MODE_PULSE) begin
                     for (int i = 0; i < rlas_pkg::LED_COUNT; i++) begin
                        colors_in[i].g = '0;
                        colors_in[i].b = '0;
                        colors_in[i].r = (red0 > rlas_pkg::RAMP_TOP) ? '0 :
                                         colors_ff[i].r + rlas_pkg::RAMP_STEP;
                     end
                     rounds_in = (red0 > rlas_pkg::RAMP_TOP) ? rounds_ff + 1'b1 : rounds_ff;
                     if (rounds_in == rlas_pkg::PULSE_ROUNDS_END) begin
                        enable_in = 1'b0;
                        supply_in = 1'b0;
                        rounds_in = '0;
                        mode_in   = rlas_pkg::MODE_OFF;
                     end
                  end else if (mode_ff == rlas_pkg::MODE_LOCK ||
                               mode_ff == rlas_pkg::MODE_OPEN) begin
                     sweep_in = sweep_n;
                     for (int i = 0; i < rlas_pkg::LED_COUNT; i++) begin
                        colors_in[i].r = '0;
                        colors_in[i].b = '0;
                        colors_in[i].g = (sweep_lit &&
                           ((rlas_pkg::SWEEP_W'(i) + 1'b1) >= sweep_n)) ? rlas_pkg::FULL_ON : '0;
                     end
                     // sweep end: lights out and the frame goes twice
                     if (sweep_n == rlas_pkg::SWEEP_END) begin
                        enable_in = 1'b0;
                        supply_in = 1'b0;
                        sweep_in  = '0;
                        mode_in   = rlas_pkg::MODE_OFF;
                        job_twice = 1'b1;
                     end
                  end
               end
            end else begin
               phase_in = '0;
            end
         end
         rlas_pkg::FUNC_MODE: begin
            if (req_mode <= rlas_pkg::MODE_OPEN) begin
               job_valid = 1'b1;
               mode_in   = req_mode;
               phase_in  = '0;
               if (req_mode == rlas_pkg::MODE_OFF) begin
                  supply_in = 1'b0;
               end else begin
                  enable_in = 1'b1;
                  supply_in = 1'b1;
                  if (req_mode == rlas_pkg::MODE_CHASE) begin
                     chase_in  = '0;
                     fade_in   = 1'b0;
                     colors_in = '0;
                  end else if (req_mode == rlas_pkg::MODE_PULSE) begin
                     rounds_in = '0;
                     colors_in = '0;
                  end else begin
                     sweep_in = '0;
                     for (int i = 0; i < rlas_pkg::LED_COUNT; i++) begin
                        colors_in[i].g = rlas_pkg::FULL_ON;
                        colors_in[i].r = '0;
                        colors_in[i].b = '0;
                     end
                  end
               end
            end
         end
         rlas_pkg::FUNC_STOP: begin
            job_valid = 1'b1;
            enable_in = 1'b0;
            supply_in = 1'b0;
            sweep_in  = '0;
            mode_in   = rlas_pkg::MODE_OFF;
            phase_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // animation state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         phase_ff  <= '0;
         mode_ff   <= rlas_pkg::MODE_OFF;
         colors_ff <= '0;
         chase_ff  <= '0;
         fade_ff   <= 1'b0;
         rounds_ff <= '0;
         sweep_ff  <= '0;
         supply_ff <= 1'b0;
      end else if (accept) begin
         enable_ff <= enable_in;
         phase_ff  <= phase_in;
         mode_ff   <= mode_in;
         colors_ff <= colors_in;
         chase_ff  <= chase_in;
         fade_ff   <= fade_in;
         rounds_ff <= rounds_in;
         sweep_ff  <= sweep_in;
         supply_ff <= supply_in;
      end
   end

   // job handed to the queue
   assign push              = accept && job_valid;
   assign push_job.leds     = colors_in;
   assign push_job.power_on = supply_in;
   assign push_job.twice    = job_twice;

endmodule

FILE: sv/rlas_queue.sv
// short job queue between the front and back parts
// depends on rlas_pkg
module rlas_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rlas_pkg::job_type          push_job,
   input  logic                       pop,
   output rlas_pkg::job_type          pop_job,
   output rlas_pkg::queue_status_type status
);

   rlas_pkg::job_type              slot_ff [rlas_pkg::QUEUE_DEPTH];
   logic [rlas_pkg::QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [rlas_pkg::QCNT_W-1:0]    count_ff;
   logic                           do_push, do_pop;

   assign status.full  = (count_ff == rlas_pkg::QCNT_W'(rlas_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == rlas_pkg::QPTR_W'(rlas_pkg::QUEUE_DEPTH - 1)) ?
                                   '0 : wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == rlas_pkg::QPTR_W'(rlas_pkg::QUEUE_DEPTH - 1)) ?
                                   '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_ff + rlas_pkg::QCNT_W'(do_push) - rlas_pkg::QCNT_W'(do_pop);
      end
   end

endmodule

FILE: sv/rlas_back.sv
// back part: walks one queued job out as GRB words, one word per cycle while rsp_stall is low
// depends on rlas_pkg
module rlas_back (
   input  logic                           clock,
   input  logic                           reset,
   input  rlas_pkg::queue_status_type     q_status,
   input  rlas_pkg::job_type              q_job,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rlas_pkg::LED_IDX_W-1:0] rsp_led_sel,
   output logic [rlas_pkg::COLOR_W-1:0]   rsp_green,
   output logic [rlas_pkg::COLOR_W-1:0]   rsp_red,
   output logic [rlas_pkg::COLOR_W-1:0]   rsp_blue,
   output logic                           rsp_power_on,
   output logic                           rsp_last
);

   rlas_pkg::job_type              job_ff;
   logic                           busy_ff;
   logic [rlas_pkg::WORD_W-1:0]    word_ff;
   logic [rlas_pkg::WORD_W-1:0]    last_word;
   logic                           taken;
   rlas_pkg::color_type            cur;

   assign last_word = job_ff.twice ? rlas_pkg::WORD_W'(2 * rlas_pkg::LED_COUNT - 1) :
                                     rlas_pkg::WORD_W'(rlas_pkg::LED_COUNT - 1);
   assign taken     = busy_ff && !rsp_stall;
   assign rsp_last  = (word_ff == last_word);
   assign pop       = !q_status.empty && (!busy_ff || (taken && rsp_last));

   // job register and word counter
   always_ff @(posedge clock) begin
      if (pop) job_ff <= q_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         word_ff <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         word_ff <= '0;
      end else if (taken) begin
         busy_ff <= !rsp_last;
         word_ff <= word_ff + 1'b1;
      end
   end

   // output word
   assign cur           = job_ff.leds[word_ff[rlas_pkg::LED_IDX_W-1:0]];
   assign rsp_valid     = busy_ff;
   assign rsp_led_sel   = word_ff[rlas_pkg::LED_IDX_W-1:0];
   assign rsp_green     = cur.g;
   assign rsp_red       = cur.r;
   assign rsp_blue      = cur.b;
   assign rsp_power_on  = job_ff.power_on;

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the rgb led animation sequencer
// holds a scoreboard class that predicts every grb word, plus tasks that drive req and csr
// depends on rlas_pkg and the rgb_led_animation_sequencer top level
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rlas_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
   localparam int MODE_BAD_LO    = MODE_OPEN + 1;
   localparam int MODE_MAX       = (1 << MODE_W) - 1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 24;

   // one expected or observed color word
   typedef struct packed {
      logic [LED_IDX_W-1:0] led;
      color_type            color;
      logic                 power;
      logic                 last;
   } led_word_type;

   // animation predictor and store of expected color words
   class led_scoreboard;
      logic [PERIOD_W-1:0]  periods [2**CSR_IDX_W];
      bit                   run_en;
      logic [PERIOD_W-1:0]  phase_cnt;
      logic [MODE_W-1:0]    cur_mode;
      color_type            leds [LED_COUNT];
      logic [LED_IDX_W-1:0] chase_led;
      bit                   fading_down;
      logic [ROUNDS_W-1:0]  rounds;
      logic [SWEEP_W-1:0]   sweep_pos;
      bit                   supply;
      led_word_type         expected_words [$];
      int                   mismatches;

      function new();
         periods[CSR_CHASE_PERIOD] = CHASE_PERIOD_RST;
         periods[CSR_PULSE_PERIOD] = PULSE_PERIOD_RST;
         periods[CSR_LOCK_PERIOD]  = LOCK_PERIOD_RST;
         periods[CSR_OPEN_PERIOD]  = OPEN_PERIOD_RST;
         run_en      = 0;
         phase_cnt   = '0;
         cur_mode    = MODE_OFF;
         foreach (leds[i]) leds[i] = '0;
         chase_led   = '0;
         fading_down = 0;
         rounds      = '0;
         sweep_pos   = '0;
         supply      = 0;
         mismatches  = 0;
      endfunction

      function void write_period(logic [CSR_IDX_W-1:0] idx, logic [PERIOD_W-1:0] value);
         periods[idx] = value;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // advance the animation for one accepted item and queue its words
      function void note_input(logic [FUNC_W-1:0] func, logic [MODE_W-1:0] mode);
         int                  frames;
         int                  i;
         int                  f;
         logic [PERIOD_W-1:0] limit;
         led_word_type        word;
         frames = 0;
         case (func)
            FUNC_TICK: begin
               if (!run_en) begin
                  phase_cnt = '0;
               end else begin
                  phase_cnt = phase_cnt + 1'b1;
                  case (cur_mode)
                     MODE_CHASE: limit = periods[CSR_CHASE_PERIOD];
                     MODE_PULSE: limit = periods[CSR_PULSE_PERIOD];
                     MODE_LOCK:  limit = periods[CSR_LOCK_PERIOD];
                     MODE_OPEN:  limit = periods[CSR_OPEN_PERIOD];
                     default:    limit = OFF_PERIOD;
                  endcase
                  if (phase_cnt >= limit) begin
                     case (cur_mode)
                        // one led breathes blue; the lit index may move mid-loop
                        MODE_CHASE: begin
                           for (i = 0; i < LED_COUNT; i++) begin
                              leds[i].r = '0;
                              leds[i].g = '0;
                              if (i == chase_led) begin
                                 if (!fading_down) begin
                                    leds[i].b = leds[i].b + RAMP_STEP;
                                    if (leds[i].b > RAMP_TOP) fading_down = 1;
                                 end else begin
                                    leds[i].b = leds[i].b - RAMP_STEP;
                                    if (leds[i].b == 0) begin
                                       fading_down = 0;
                                       chase_led   = chase_led + 1'b1;
                                    end
                                 end
                              end else begin
                                 leds[i].b = '0;
                              end
                           end
                        end
                        // red ramp on all leds, ends after three rounds
                        MODE_PULSE: begin
                           for (i = 0; i < LED_COUNT; i++) begin
                              leds[i].g = '0;
                              leds[i].b = '0;
                              leds[i].r = leds[i].r + RAMP_STEP;
                           end
                           if (leds[0].r > RAMP_TOP) begin
                              for (i = 0; i < LED_COUNT; i++) leds[i].r = '0;
                              rounds = rounds + 1'b1;
                           end
                           if (rounds == PULSE_ROUNDS_END) begin
                              run_en   = 0;
                              supply   = 0;
                              rounds   = '0;
                              cur_mode = MODE_OFF;
                           end
                        end
                        // green cleared from the left, double frame at the end
                        MODE_LOCK, MODE_OPEN: begin
                           sweep_pos = sweep_pos + 1'b1;
                           foreach (leds[k]) leds[k] = '0;
                           if (sweep_pos >= 1 && sweep_pos <= LED_COUNT) begin
                              for (i = sweep_pos - 1; i < LED_COUNT; i++) leds[i].g = FULL_ON;
                           end else if (sweep_pos == SWEEP_END) begin
                              run_en    = 0;
                              supply    = 0;
                              sweep_pos = '0;
                              cur_mode  = MODE_OFF;
                              frames    = 1;
                           end
                        end
                        default: ;
                     endcase
                     frames++;
                     phase_cnt = '0;
                  end
               end
            end
            FUNC_MODE: begin
               if (mode <= MODE_OPEN) begin
                  cur_mode = mode;
                  if (mode == MODE_OFF) begin
                     supply = 0;
                  end else begin
                     run_en = 1;
                     supply = 1;
                     case (mode)
                        MODE_CHASE: begin
                           chase_led   = '0;
                           fading_down = 0;
                           foreach (leds[k]) leds[k] = '0;
                        end
                        MODE_PULSE: begin
                           rounds = '0;
                           foreach (leds[k]) leds[k] = '0;
                        end
                        default: begin
                           sweep_pos = '0;
                           foreach (leds[k]) leds[k] = '{g: FULL_ON, r: '0, b: '0};
                        end
                     endcase
                  end
                  phase_cnt = '0;
                  frames    = 1;
               end
            end
            FUNC_STOP: begin
               run_en    = 0;
               supply    = 0;
               sweep_pos = '0;
               cur_mode  = MODE_OFF;
               phase_cnt = '0;
               frames    = 1;
            end
            default: ;
         endcase
         // every frame carries the state after the whole item
         for (f = 0; f < frames; f++) begin
            for (i = 0; i < LED_COUNT; i++) begin
               word.led   = LED_IDX_W'(i);
               word.color = leds[i];
               word.power = supply;
               word.last  = (f == frames - 1) && (i == LED_COUNT - 1);
               expected_words.push_back(word);
            end
         end
      endfunction

      task report(input string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      // compare one delivered word with the oldest expected one
      task check_word(input led_word_type got);
         led_word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("word for led %0d with nothing expected", got.led));
            return;
         end
         want = expected_words.pop_front();
         if (got.led != want.led)
            report($sformatf("led_sel got %0d want %0d", got.led, want.led));
         if (got.color.g != want.color.g)
            report($sformatf("led %0d green got %0d want %0d", want.led, got.color.g,
                             want.color.g));
         if (got.color.r != want.color.r)
            report($sformatf("led %0d red got %0d want %0d", want.led, got.color.r,
                             want.color.r));
         if (got.color.b != want.color.b)
            report($sformatf("led %0d blue got %0d want %0d", want.led, got.color.b,
                             want.color.b));
         if (got.power != want.power)
            report($sformatf("led %0d power_on got %0d want %0d", want.led, got.power,
                             want.power));
         if (got.last != want.last)
            report($sformatf("led %0d last got %0d want %0d", want.led, got.last, want.last));
      endtask
   endclass

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func  = FUNC_TICK;
   logic [MODE_W-1:0]    req_mode  = MODE_OFF;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [LED_IDX_W-1:0] rsp_led_sel;
   logic [COLOR_W-1:0]   rsp_green;
   logic [COLOR_W-1:0]   rsp_red;
   logic [COLOR_W-1:0]   rsp_blue;
   logic                 rsp_power_on;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CHASE_PERIOD;
   logic [PERIOD_W-1:0]  csr_data  = '0;

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int quiet_cycles  = 0;

   led_scoreboard sb;

   rgb_led_animation_sequencer u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_mode      (req_mode),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_led_sel   (rsp_led_sel),
      .rsp_green     (rsp_green),
      .rsp_red       (rsp_red),
      .rsp_blue      (rsp_blue),
      .rsp_power_on  (rsp_power_on),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // random receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   // handshake monitor: results are checked before the new item is predicted
   always @(posedge clock) begin : monitor
      bit           progress;
      led_word_type got;
      if (!reset) begin
         progress = 0;
         if (rsp_valid && !rsp_stall) begin
            got.led     = rsp_led_sel;
            got.color.g = rsp_green;
            got.color.r = rsp_red;
            got.color.b = rsp_blue;
            got.power   = rsp_power_on;
            got.last    = rsp_last;
            sb.check_word(got);
            progress = 1;
         end
         if (req_valid && !req_stall) begin
            sb.note_input(req_func, req_mode);
            progress = 1;
         end
         if (csr_valid && csr_ready) begin
            sb.write_period(csr_index, csr_data);
            progress = 1;
         end
         // watchdog on cycles with no handshake at all
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // offer one item after a random gap, return at the edge that takes it
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [MODE_W-1:0] mode);
      int gap;
      bit stalled;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_mode  <= mode;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(FUNC_TICK, MODE_W'($urandom));
   endtask

   // hold the sender until every expected word is in, then wait a little more
   task automatic quiesce(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
      bit busy;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(negedge clock);
         busy = !csr_ready;
         @(posedge clock);
      end while (busy);
   endtask

   task automatic configure(input logic [PERIOD_W-1:0] chase_p, pulse_p, lock_p, open_p);
      write_reg(CSR_CHASE_PERIOD, chase_p);
      write_reg(CSR_PULSE_PERIOD, pulse_p);
      write_reg(CSR_LOCK_PERIOD, lock_p);
      write_reg(CSR_OPEN_PERIOD, open_p);
      csr_valid <= 1'b0;
   endtask

   // a long run in one mode, then random sequences with some noise
   task automatic run_phase(input logic [MODE_W-1:0] lead_mode, input int lead_ticks,
                            input int n_random);
      int done;
      int pick;
      int len;
      send_item(FUNC_MODE, lead_mode);
      send_ticks(lead_ticks);
      done = 0;
      while (done < n_random) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = $urandom_range(1, 24);
            if (len > n_random - done) len = n_random - done;
            send_ticks(len);
            done += len;
         end else if (pick < 75) begin
            send_item(FUNC_MODE, MODE_W'($urandom_range(MODE_OFF, MODE_OPEN)));
            done++;
         end else if (pick < 82) begin
            send_item(FUNC_STOP, MODE_W'($urandom));
            done++;
         end else if (pick < 88) begin
            // ignored items
            if ($urandom_range(0, 1))
               send_item(FUNC_RESERVED, MODE_W'($urandom));
            else
               send_item(FUNC_MODE, MODE_W'($urandom_range(MODE_BAD_LO, MODE_MAX)));
         end else if (pick < 96) begin
            len = $urandom_range(40, 120);
            if (len > n_random - done) len = n_random - done;
            send_ticks(len);
            done += len;
         end else begin
            quiesce(0);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: every function, ignored items, off while running, full sweep
      send_idle_pct = 7;
      rcv_idle_pct  = 82;
      configure(8'd2, 8'd1, 8'd1, 8'd1);
      send_item(FUNC_TICK, MODE_OFF);
      send_item(FUNC_RESERVED, MODE_W'(MODE_MAX));
      send_item(FUNC_MODE, MODE_W'(MODE_MAX));
      send_item(FUNC_MODE, MODE_OFF);
      send_item(FUNC_MODE, MODE_CHASE);
      send_ticks(2);
      send_item(FUNC_MODE, MODE_OFF);
      send_ticks(2);
      send_item(FUNC_MODE, MODE_LOCK);
      send_ticks(6);
      send_item(FUNC_MODE, MODE_PULSE);
      send_ticks(2);
      send_item(FUNC_STOP, MODE_W'(MODE_MAX));
      send_item(FUNC_MODE, MODE_OPEN);
      send_ticks(1);
      send_item(FUNC_STOP, MODE_OFF);
      quiesce(SETTLE_CYCLES);

      // fast periods, chase runs long enough to move to the next led
      configure(8'd1, 8'd3, 8'd1, 8'd2);
      run_phase(MODE_CHASE, 110, 30);
      quiesce(SETTLE_CYCLES);

      // zero periods, pulse runs through all three rounds
      send_idle_pct = 82;
      rcv_idle_pct  = 7;
      configure(8'd0, 8'd0, 8'd0, 8'd2);
      run_phase(MODE_PULSE, 156, 20);
      quiesce(SETTLE_CYCLES);

      // long periods, one lock step after a long count
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      configure(8'd255, 8'd255, 8'd120, 8'd255);
      run_phase(MODE_LOCK, 122, 5);
      quiesce(SETTLE_CYCLES);

      if (sb.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
